/* rtl/pfba_pkg.sv */
// ----------------------------------------------------------------------------
// pfba_pkg: shared types and constants of the page frame bitmap allocator
// Holds the request and response payloads, the request kinds and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pfba_pkg;

	// Geometry of the tracked memory.
	localparam int MAX_PAGES   = 65536;
	localparam int PAGE_BYTES  = 4096;
	localparam int STORE_BYTES = (MAX_PAGES + 7) / 8;

	// The bitmap is stored as rows of 64 page bits each.
	localparam int ROW_BITS  = 64;
	localparam int ROWS      = MAX_PAGES / ROW_BITS;
	localparam int ROW_AW    = $clog2(ROWS);
	localparam int COL_W     = $clog2(ROW_BITS);
	localparam int BYTE_COLS = ROW_BITS / 8;
	localparam int BYIX_W    = $clog2(BYTE_COLS);

	// Page index and page limit widths.
	localparam int PG_IX_W    = $clog2(MAX_PAGES);
	localparam int PAGE_W     = PG_IX_W + 1;
	localparam int BYTES_W    = PAGE_W - 3;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

	// Field widths.
	localparam int KIND_W = 2;
	localparam int ADDR_W = 32;
	localparam int CNT_W  = 17;
	localparam int FA_W   = 28;
	localparam int CFG_W  = 14;

	localparam logic [CFG_W-1:0] BYTES_AT_RESET = CFG_W'(8192);

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_USED  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] start_address;
		logic [CNT_W-1:0]  page_count;
	} req_t;

	typedef struct packed {
		logic [FA_W-1:0] frame_address;
		logic            found;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic init_wr;
		logic rd;
		logic chk;
		logic row_inc;
		logic wr_range;
		logic wr_alloc;
		logic res_set;
		logic res_found;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic init_last;
		logic alloc_empty;
		logic range_empty;
		logic row_last;
		logic row_free;
	} stat_t;

endpackage

/* rtl/pfba_ram.sv */
// ----------------------------------------------------------------------------
// pfba_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered and holds
// its value between reads.
// ----------------------------------------------------------------------------
module pfba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/pfba_ctrl.sv */
// ----------------------------------------------------------------------------
// pfba_ctrl: controller of the page frame bitmap allocator
// Sequences the clearing pass after reset, the row scan of an allocation
// and the read-modify-write walk of a range request.
// ----------------------------------------------------------------------------
module pfba_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pfba_pkg::KIND_W-1:0]  kind,
	input  pfba_pkg::stat_t              stat,
	output pfba_pkg::cmd_t               cmd,
	output logic                         busy,
	output logic                         done
);

	import pfba_pkg::*;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_A_RD,
		ST_A_CHK,
		ST_A_BIT,
		ST_R_RD,
		ST_R_WR
	} state_t;

	state_t state_q, state_d;
	logic   done_q, done_d;

	// Next state and datapath commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		done_d  = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (stat.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (kind)
						KIND_ALLOC: begin
							if (stat.alloc_empty) begin
								cmd.res_set = 1'b1;
								done_d      = 1'b1;
							end else begin
								state_d = ST_A_RD;
							end
						end
						KIND_USED, KIND_FREE: begin
							if (stat.range_empty) begin
								cmd.res_set = 1'b1;
								done_d      = 1'b1;
							end else begin
								state_d = ST_R_RD;
							end
						end
						default: begin
							cmd.res_set = 1'b1;
							done_d      = 1'b1;
						end
					endcase
				end
			end
			ST_A_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_A_CHK;
			end
			ST_A_CHK: begin
				cmd.chk = 1'b1;
				if (stat.row_free) begin
					state_d = ST_A_BIT;
				end else if (stat.row_last) begin
					cmd.res_set = 1'b1;
					done_d      = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.row_inc = 1'b1;
					state_d     = ST_A_RD;
				end
			end
			ST_A_BIT: begin
				cmd.wr_alloc  = 1'b1;
				cmd.res_set   = 1'b1;
				cmd.res_found = 1'b1;
				done_d        = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_R_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_R_WR;
			end
			ST_R_WR: begin
				cmd.wr_range = 1'b1;
				if (stat.row_last) begin
					cmd.res_set = 1'b1;
					done_d      = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.row_inc = 1'b1;
					state_d     = ST_R_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and the registered result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

/* rtl/pfba_dp.sv */
// ----------------------------------------------------------------------------
// pfba_dp: datapath of the page frame bitmap allocator
// Holds the length register, the bitmap RAM, the row walker with its range
// bounds, the free-bit search and the response register.
// ----------------------------------------------------------------------------
module pfba_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pfba_pkg::req_t              req,
	input  logic                        cfg_valid,
	input  logic [pfba_pkg::CFG_W-1:0]  cfg_data,
	input  pfba_pkg::cmd_t              cmd,
	output pfba_pkg::stat_t             stat,
	output pfba_pkg::rsp_t              rsp
);

	import pfba_pkg::*;

	localparam int FP_W  = ADDR_W - PAGE_SHIFT;
	localparam int MX1_W = (FP_W > CNT_W) ? FP_W : CNT_W;
	localparam int END_W = ((MX1_W > PAGE_W) ? MX1_W : PAGE_W) + 1;
	localparam logic [ROW_BITS-1:0] ONES = '1;

	// Length register and the derived page limit.
	logic [CFG_W-1:0]   bitmap_bytes_q;
	logic [BYTES_W-1:0] bytes_eff;
	logic [PAGE_W-1:0]  limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_bytes_q <= BYTES_AT_RESET;
		end else if (cfg_valid) begin
			bitmap_bytes_q <= cfg_data;
		end
	end

	always_comb begin
		if (32'(bitmap_bytes_q) > 32'(STORE_BYTES)) begin
			bytes_eff = BYTES_W'(STORE_BYTES);
		end else begin
			bytes_eff = BYTES_W'(bitmap_bytes_q);
		end
	end
	assign limit = {bytes_eff, 3'b000};

	// Bounds of the incoming request, clipped to the page limit.
	logic [FP_W-1:0]  first_pg;
	logic [END_W-1:0] first_x, end_x, limit_x, end_c, last_x, lim_last;

	assign first_pg = req.start_address[ADDR_W-1:PAGE_SHIFT];
	assign first_x  = END_W'(first_pg);
	assign end_x    = first_x + END_W'(req.page_count);
	assign limit_x  = END_W'(limit);
	assign end_c    = (end_x < limit_x) ? end_x : limit_x;
	assign last_x   = end_c - END_W'(1);
	assign lim_last = limit_x - END_W'(1);

	// Row walker registers.
	logic [ROW_AW-1:0] row_q, first_row_q, last_row_q, init_cnt_q;
	logic [COL_W-1:0]  lo_q, hi_q;
	logic [KIND_W-1:0] kind_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req.kind;
			if (req.kind == KIND_ALLOC) begin
				row_q       <= '0;
				first_row_q <= '0;
				lo_q        <= '0;
				last_row_q  <= lim_last[PG_IX_W-1:COL_W];
				hi_q        <= lim_last[COL_W-1:0];
			end else begin
				row_q       <= first_x[PG_IX_W-1:COL_W];
				first_row_q <= first_x[PG_IX_W-1:COL_W];
				lo_q        <= first_x[COL_W-1:0];
				last_row_q  <= last_x[PG_IX_W-1:COL_W];
				hi_q        <= last_x[COL_W-1:0];
			end
		end else if (cmd.row_inc) begin
			row_q <= row_q + ROW_AW'(1);
		end
	end

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q <= '0;
		end else if (cmd.init_wr) begin
			init_cnt_q <= init_cnt_q + ROW_AW'(1);
		end
	end

	// Bits of the current row that lie inside the request's bounds.
	logic [ROW_BITS-1:0] row_mask;

	always_comb begin
		row_mask = ONES;
		if (row_q == first_row_q) begin
			row_mask = row_mask & (ONES << lo_q);
		end
		if (row_q == last_row_q) begin
			row_mask = row_mask & (ONES >> (COL_W'(ROW_BITS - 1) - hi_q));
		end
	end

	// Bitmap RAM.
	logic                ram_we;
	logic [ROW_AW-1:0]   ram_waddr;
	logic [ROW_BITS-1:0] ram_wdata, rd_data;

	pfba_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(ROWS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd),
		.raddr(row_q),
		.rdata(rd_data)
	);

	// Lowest free byte of the row just read.
	logic [ROW_BITS-1:0]  free_bits;
	logic [BYTE_COLS-1:0] byte_nz;
	logic [BYIX_W-1:0]    byte_sel;

	always_comb begin
		free_bits = ~rd_data & row_mask;
		byte_sel  = '0;
		for (int j = 0; j < BYTE_COLS; j++) begin
			byte_nz[j] = |free_bits[j*8 +: 8];
		end
		for (int j = BYTE_COLS - 1; j >= 0; j--) begin
			if (byte_nz[j]) begin
				byte_sel = BYIX_W'(j);
			end
		end
	end

	logic [ROW_BITS-1:0] data_q;
	logic [7:0]          free_byte_q;
	logic [BYIX_W-1:0]   byte_ix_q;

	always_ff @(posedge clk) begin
		if (cmd.chk) begin
			data_q      <= rd_data;
			free_byte_q <= free_bits[{byte_sel, 3'b000} +: 8];
			byte_ix_q   <= byte_sel;
		end
	end

	// Lowest free bit within the chosen byte, and the page it names.
	logic [2:0]                    bit_sel;
	logic [COL_W-1:0]              col;
	logic [PG_IX_W-1:0]            page;
	logic [PG_IX_W+PAGE_SHIFT-1:0] fa_wide;

	always_comb begin
		bit_sel = '0;
		for (int j = 7; j >= 0; j--) begin
			if (free_byte_q[j]) begin
				bit_sel = 3'(j);
			end
		end
	end

	assign col     = {byte_ix_q, bit_sel};
	assign page    = {row_q, col};
	assign fa_wide = {page, {PAGE_SHIFT{1'b0}}};

	// RAM write selection: clearing pass, range update or frame claim.
	always_comb begin
		ram_we    = cmd.init_wr | cmd.wr_range | cmd.wr_alloc;
		ram_waddr = cmd.init_wr ? init_cnt_q : row_q;
		if (cmd.init_wr) begin
			ram_wdata = ONES;
		end else if (cmd.wr_alloc) begin
			ram_wdata = data_q | (ROW_BITS'(1) << col);
		end else if (kind_q == KIND_USED) begin
			ram_wdata = rd_data | row_mask;
		end else begin
			ram_wdata = rd_data & ~row_mask;
		end
	end

	// Response register.
	rsp_t rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			rsp_q.found         <= cmd.res_found;
			rsp_q.frame_address <= cmd.res_found ? FA_W'(fa_wide) : '0;
		end
	end

	assign rsp = rsp_q;

	// Status to the controller.
	assign stat.init_last   = (init_cnt_q == ROW_AW'(ROWS - 1));
	assign stat.alloc_empty = (limit == '0);
	assign stat.range_empty = (first_x >= end_c);
	assign stat.row_last    = (row_q == last_row_q);
	assign stat.row_free    = |byte_nz;

endmodule

/* rtl/page_frame_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator: bitmap page frame allocator, top level
// An allocate scans the rows (64 pages per row) from row 0, reading and checking
// each one in turn, and claims the lowest free bit of the first row that has one;
// a range request reads and writes back each 64-page row it touches.
// Requests with nothing to do report in the next cycle. One request at a time.
// Reset: a clearing pass marks every page used; busy is high.
// The result strobe done lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  pfba_pkg::req_t              req,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pfba_pkg::CFG_W-1:0]  cfg_data,
	output logic                        done,
	output pfba_pkg::rsp_t              rsp
);

	import pfba_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// The length register accepts a write in any cycle.
	assign cfg_ready = 1'b1;

	// Controller.
	pfba_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.kind  (req.kind),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// Datapath.
	pfba_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.rsp      (rsp)
	);

	// An accepted transaction either occupies the block or reports at once.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction neither busy nor reported");

	// The block only becomes busy because a transaction was accepted.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy raised without an accepted transaction");

	// A result without a frame carries address zero.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.found) |-> (rsp.frame_address == '0))
		else $error("result without frame has nonzero address");

	// The bitmap is never written in the cycle a row read is issued.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !(cmd.wr_range || cmd.wr_alloc || cmd.init_wr))
		else $error("bitmap read and write issued together");

endmodule
